// File: rtl/jpeg_frame_header_scanner_top_defines.svh
// ----------------------------------------------------------------------------
// jpeg frame header scanner assertion macros
// clocked on i_clk, quiet while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef JPEG_FRAME_HEADER_SCANNER_TOP_DEFINES_SVH
`define JPEG_FRAME_HEADER_SCANNER_TOP_DEFINES_SVH

// same-cycle implication
`define JFHS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("jfhs assertion failed");

// next-cycle implication
`define JFHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("jfhs assertion failed");

`endif

// File: rtl/jfhs_pkg.sv
// ----------------------------------------------------------------------------
// jfhs_pkg
// types, codes and helpers shared by the jpeg frame header scanner
// ----------------------------------------------------------------------------
package jfhs_pkg;

    localparam logic [7:0] MARKER_PREFIX = 8'hff;

    typedef logic [1:0] t_status;
    localparam t_status ST_VALID    = 2'd0;
    localparam t_status ST_NOTFOUND = 2'd1;
    localparam t_status ST_BAD      = 2'd2;

    typedef enum logic [8:0] {
        PH_LEAD0  = 9'b000000001,
        PH_LEAD1  = 9'b000000010,
        PH_SEEK   = 9'b000000100,
        PH_MARKER = 9'b000001000,
        PH_LENHI  = 9'b000010000,
        PH_LENLO  = 9'b000100000,
        PH_SKIP   = 9'b001000000,
        PH_FRAME  = 9'b010000000,
        PH_DONE   = 9'b100000000
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [7:0]  component_count;
    } t_result;

    typedef struct packed {
        t_phase phase;
        logic   reported;
    } t_par_status;

    typedef struct packed {
        logic [1:0] level;
    } t_buf_status;

    // start-of-frame codes: c0-c3, c5-c7, c9-cb, cd-cf
    function automatic logic is_sof(input logic [7:0] code);
        logic hit;
        begin
            hit = (code[7:4] == 4'hc) && (code[1:0] != 2'b00 || code[3:2] == 2'b00);
            return hit;
        end
    endfunction

endpackage

// File: rtl/jfhs_parser.sv
// ----------------------------------------------------------------------------
// jfhs_parser
// marker state machine; one registered byte in, at most one result out
// ----------------------------------------------------------------------------
module jfhs_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output logic                  o_res_valid,
    output jfhs_pkg::t_result     o_res,
    output jfhs_pkg::t_par_status o_stat
);
    import jfhs_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [15:0] r_skip_cnt, n_skip_cnt;
    logic [7:0]  r_len_hi,   n_len_hi;
    logic [2:0]  r_fld_idx,  n_fld_idx;
    logic [15:0] r_height,   n_height;
    logic [15:0] r_width,    n_width;
    logic [7:0]  r_comps,    n_comps;
    logic        r_reported, n_reported;

    logic [15:0] w_len;
    logic        w_emit;
    logic        w_ok;

    assign w_len = {r_len_hi, i_byte};
    assign w_ok  = (r_width != 16'd0) && (r_height != 16'd0) &&
                   (i_byte == 8'd1 || i_byte == 8'd3);

    always_comb begin
        n_phase    = r_phase;
        n_skip_cnt = r_skip_cnt;
        n_len_hi   = r_len_hi;
        n_fld_idx  = r_fld_idx;
        n_height   = r_height;
        n_width    = r_width;
        n_comps    = r_comps;
        n_reported = r_reported;
        w_emit     = 1'b0;
        o_res      = '{status: ST_NOTFOUND, image_width: 16'd0,
                       image_height: 16'd0, component_count: 8'd0};

        unique case (r_phase)
            PH_LEAD0: n_phase = PH_LEAD1;
            PH_LEAD1: n_phase = PH_SEEK;
            PH_SEEK: begin
                if (i_byte == MARKER_PREFIX) n_phase = PH_MARKER;
            end
            PH_MARKER: begin
                // fill bytes keep us here
                if (i_byte != MARKER_PREFIX) begin
                    if (is_sof(i_byte)) begin
                        n_fld_idx = 3'd0;
                        n_phase   = PH_FRAME;
                    end else begin
                        n_phase = PH_LENHI;
                    end
                end
            end
            PH_LENHI: begin
                n_len_hi = i_byte;
                n_phase  = PH_LENLO;
            end
            PH_LENLO: begin
                // length counts its own two bytes
                n_skip_cnt = (w_len >= 16'd2) ? w_len - 16'd2 : 16'd0;
                n_phase    = (w_len <= 16'd2) ? PH_SEEK : PH_SKIP;
            end
            PH_SKIP: begin
                if (r_skip_cnt != 16'd0) n_skip_cnt = r_skip_cnt - 16'd1;
                if (r_skip_cnt <= 16'd1) n_phase = PH_SEEK;
            end
            PH_FRAME: begin
                case (r_fld_idx)
                    3'd3:    n_height[15:8] = i_byte;
                    3'd4:    n_height[7:0]  = i_byte;
                    3'd5:    n_width[15:8]  = i_byte;
                    3'd6:    n_width[7:0]   = i_byte;
                    3'd7:    n_comps        = i_byte;
                    default: ;
                endcase
                if (r_fld_idx == 3'd7) begin
                    w_emit     = 1'b1;
                    o_res      = '{status: w_ok ? ST_VALID : ST_BAD,
                                   image_width: r_width, image_height: r_height,
                                   component_count: i_byte};
                    n_reported = 1'b1;
                    n_phase    = PH_DONE;
                end else begin
                    n_fld_idx = r_fld_idx + 3'd1;
                end
            end
            default: n_phase = PH_DONE;
        endcase

        if (i_last) begin
            if (!n_reported) w_emit = 1'b1;
            n_phase    = PH_LEAD0;
            n_skip_cnt = 16'd0;
            n_len_hi   = 8'd0;
            n_fld_idx  = 3'd0;
            n_height   = 16'd0;
            n_width    = 16'd0;
            n_comps    = 8'd0;
            n_reported = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LEAD0;
            r_skip_cnt <= 16'd0;
            r_len_hi   <= 8'd0;
            r_fld_idx  <= 3'd0;
            r_height   <= 16'd0;
            r_width    <= 16'd0;
            r_comps    <= 8'd0;
            r_reported <= 1'b0;
        end else if (i_valid) begin
            r_phase    <= n_phase;
            r_skip_cnt <= n_skip_cnt;
            r_len_hi   <= n_len_hi;
            r_fld_idx  <= n_fld_idx;
            r_height   <= n_height;
            r_width    <= n_width;
            r_comps    <= n_comps;
            r_reported <= n_reported;
        end
    end

    assign o_res_valid = i_valid && w_emit;
    assign o_stat      = '{phase: r_phase, reported: r_reported};

endmodule

// File: rtl/jfhs_out_buf.sv
// ----------------------------------------------------------------------------
// jfhs_out_buf
// two-entry result queue in front of the output stream
// ----------------------------------------------------------------------------
module jfhs_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  jfhs_pkg::t_result     i_res,
    input  logic                  i_pop,
    output logic                  o_valid,
    output jfhs_pkg::t_result     o_res,
    output jfhs_pkg::t_buf_status o_stat
);
    import jfhs_pkg::*;

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       w_pop;

    assign w_pop = i_pop && (r_level != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wr_ptr] <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({i_push, w_pop})
                2'b10:   r_level <= r_level + 2'd1;
                2'b01:   r_level <= r_level - 2'd1;
                default: ;
            endcase
        end
    end

    assign o_valid = (r_level != 2'd0);
    assign o_res   = r_slot[r_rd_ptr];
    assign o_stat  = '{level: r_level};

endmodule

// File: rtl/jpeg_frame_header_scanner_top.sv
// ----------------------------------------------------------------------------
// jpeg_frame_header_scanner_top
// finds the first start-of-frame header in a byte stream of a jpeg file
// ----------------------------------------------------------------------------
// Feed one file byte per beat with tlast on its final byte. The block takes a
// byte every cycle while s_axis_tready is high; each byte is registered, then the
// marker logic updates the parser and may push one result into a two-entry
// output queue, whose registered level drives the master side. Exactly
// one result comes per file: the frame header (status in tuser, 0 valid,
// 2 bad size or component count) or, at the last byte, status 1 not found.
// s_axis_tready drops only when the queue is full, or when it holds one result
// that the master side is not taking while a byte is in flight. After the
// last byte the parser re-arms for a new file.
`include "jpeg_frame_header_scanner_top_defines.svh"

module jpeg_frame_header_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] image_width, [31:16] image_height,
                                        // [39:32] component_count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import jfhs_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        w_accept;
    logic        w_res_valid;
    t_result     w_res;
    t_result     w_out_res;
    t_par_status w_par_stat;
    t_buf_status w_buf_stat;

    // a queued result leaving this cycle frees the slot for the byte in flight
    assign s_axis_tready = (w_buf_stat.level == 2'd0) ||
                           (w_buf_stat.level == 2'd1 && (!r_in_valid || m_axis_tready));
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    jfhs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_stat      (w_par_stat)
    );

    jfhs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .i_pop   (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (w_out_res),
        .o_stat  (w_buf_stat)
    );

    assign m_axis_tdata = {w_out_res.component_count, w_out_res.image_height,
                           w_out_res.image_width};
    assign m_axis_tuser = w_out_res.status;

    // a result never lands on a full queue
    `JFHS_ASSERT_IMPL(a_push_room, w_res_valid, w_buf_stat.level != 2'd2)
    // not-found comes only with the last byte of a file
    `JFHS_ASSERT_IMPL(a_notfound_last, w_res_valid && w_res.status == ST_NOTFOUND, r_in_last)
    // the parser re-arms after the last byte
    `JFHS_ASSERT_NEXT(a_rearm, r_in_valid && r_in_last,
                      w_par_stat.phase == PH_LEAD0 && !w_par_stat.reported)

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the jpeg frame header scanner against a byte-level parser model:
// directed files for fill bytes, short lengths, header on the last byte, max
// sizes and a bad component count, then random well-formed, broken and noise
// files under random stalls on both stream sides
// ----------------------------------------------------------------------------
module tb_top;
    import jfhs_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // byte positions inside the frame header segment
    localparam logic [2:0] FLD_HEIGHT_HI = 3'd3;
    localparam logic [2:0] FLD_HEIGHT_LO = 3'd4;
    localparam logic [2:0] FLD_WIDTH_HI  = 3'd5;
    localparam logic [2:0] FLD_WIDTH_LO  = 3'd6;
    localparam logic [2:0] FLD_COMPS     = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [15:0] image_width, [31:16] image_height,
                                 // [39:32] component_count
    logic [1:0]  m_axis_tuser;   // [1:0] status

    jpeg_frame_header_scanner_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    class header_tracker;
        t_phase      phase;
        logic [15:0] skip_left;
        logic [7:0]  len_hi;
        logic [2:0]  field_idx;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  comps;
        logic        reported;
        t_result     expected_headers[$];
        int          errors;

        function new();
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            phase     = PH_LEAD0;
            skip_left = '0;
            len_hi    = '0;
            field_idx = '0;
            height    = '0;
            width     = '0;
            comps     = '0;
            reported  = 1'b0;
        endfunction

        function bit is_frame_code(logic [7:0] code);
            case (code)
                8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc5, 8'hc6, 8'hc7,
                8'hc9, 8'hca, 8'hcb, 8'hcd, 8'hce, 8'hcf: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        // advance the parser by one accepted byte, queue any result it yields
        function void note_byte(logic [7:0] b, logic last);
            logic [15:0] seg_len;
            t_result     hdr;
            bit          emitted;
            emitted = 1'b0;
            case (phase)
                PH_LEAD0: phase = PH_LEAD1;
                PH_LEAD1: phase = PH_SEEK;
                PH_SEEK: begin
                    if (b == MARKER_PREFIX) phase = PH_MARKER;
                end
                PH_MARKER: begin
                    if (b != MARKER_PREFIX) begin
                        if (is_frame_code(b)) begin
                            field_idx = '0;
                            phase     = PH_FRAME;
                        end else begin
                            phase = PH_LENHI;
                        end
                    end
                end
                PH_LENHI: begin
                    len_hi = b;
                    phase  = PH_LENLO;
                end
                PH_LENLO: begin
                    seg_len   = {len_hi, b};
                    skip_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                    phase     = (skip_left == 16'd0) ? PH_SEEK : PH_SKIP;
                end
                PH_SKIP: begin
                    if (skip_left != 16'd0) skip_left = skip_left - 16'd1;
                    if (skip_left == 16'd0) phase = PH_SEEK;
                end
                PH_FRAME: begin
                    case (field_idx)
                        FLD_HEIGHT_HI: height[15:8] = b;
                        FLD_HEIGHT_LO: height[7:0]  = b;
                        FLD_WIDTH_HI:  width[15:8]  = b;
                        FLD_WIDTH_LO:  width[7:0]   = b;
                        FLD_COMPS:     comps        = b;
                        default: ;
                    endcase
                    if (field_idx == FLD_COMPS) begin
                        hdr.status = (width != 0 && height != 0 &&
                                      (comps == 8'd1 || comps == 8'd3)) ? ST_VALID : ST_BAD;
                        hdr.image_width     = width;
                        hdr.image_height    = height;
                        hdr.component_count = comps;
                        expected_headers.push_back(hdr);
                        emitted  = 1'b1;
                        reported = 1'b1;
                        phase    = PH_DONE;
                    end else begin
                        field_idx = field_idx + 3'd1;
                    end
                end
                default: phase = PH_DONE;
            endcase
            if (last) begin
                if (!emitted && !reported) begin
                    hdr.status          = ST_NOTFOUND;
                    hdr.image_width     = '0;
                    hdr.image_height    = '0;
                    hdr.component_count = '0;
                    expected_headers.push_back(hdr);
                end
                rearm();
            end
        endfunction

        function void check_header(logic [39:0] data, logic [1:0] user);
            t_result want;
            if (expected_headers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d data %h",
                         $time, user, data);
                errors++;
                return;
            end
            want = expected_headers.pop_front();
            if (user !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, user);
                errors++;
            end
            if (data[15:0] !== want.image_width) begin
                $display("%0t: width expected %h actual %h", $time, want.image_width,
                         data[15:0]);
                errors++;
            end
            if (data[31:16] !== want.image_height) begin
                $display("%0t: height expected %h actual %h", $time, want.image_height,
                         data[31:16]);
                errors++;
            end
            if (data[39:32] !== want.component_count) begin
                $display("%0t: components expected %h actual %h", $time,
                         want.component_count, data[39:32]);
                errors++;
            end
        endfunction
    endclass

    header_tracker tracker;
    logic [7:0]    file_bytes[$];
    int            sent_count = 0;
    int            cycles = 0;
    bit            quiet = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_header(m_axis_tdata, m_axis_tuser);
    end

    // result side stalls in short bursts
    initial begin
        int stall_len;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_len = $urandom_range(1, 4);
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_byte(b, last);
        sent_count++;
    endtask

    task automatic source_gap();
        int gap_len;
        gap_len = $urandom_range(1, 4);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (gap_len - 1) @(negedge i_clk);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
            if (!quiet && $urandom_range(0, 4) == 0) source_gap();
        end
    endtask

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // 0xff then up to two fill bytes
    function automatic void push_marker_prefix();
        file_bytes.push_back(MARKER_PREFIX);
        repeat ($urandom_range(0, 2)) file_bytes.push_back(MARKER_PREFIX);
    endfunction

    function automatic void build_random_file();
        int          nlen;
        logic [7:0]  code;
        logic [15:0] seg_len;
        file_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise, heavy on 0xff
            nlen = $urandom_range(1, 12);
            repeat (nlen)
                file_bytes.push_back(($urandom_range(0, 3) == 0) ? MARKER_PREFIX
                                                                 : 8'($urandom));
            return;
        end
        if ($urandom_range(0, 1) == 0) begin
            file_bytes.push_back(8'hff);
            file_bytes.push_back(8'hd8);
        end else begin
            file_bytes.push_back(8'($urandom));
            file_bytes.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 2)) file_bytes.push_back(8'($urandom_range(0, 254)));
        repeat ($urandom_range(0, 3)) begin
            push_marker_prefix();
            do begin
                code = ($urandom_range(0, 1) == 0) ? {4'hc, 4'($urandom)} : 8'($urandom);
            end while (tracker.is_frame_code(code) || code == MARKER_PREFIX);
            file_bytes.push_back(code);
            seg_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                  : 16'($urandom_range(2, 10));
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            if (seg_len >= 16'd2)
                repeat (seg_len - 16'd2) file_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(0, 4) != 0) begin
            push_marker_prefix();
            do code = {4'hc, 4'($urandom)}; while (!tracker.is_frame_code(code));
            file_bytes.push_back(code);
            // length and precision are not checked by the parser
            repeat (3) file_bytes.push_back(8'($urandom));
            seg_len = pick_dim();
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            seg_len = pick_dim();
            file_bytes.push_back(seg_len[15:8]);
            file_bytes.push_back(seg_len[7:0]);
            case ($urandom_range(0, 7))
                0, 1, 2: file_bytes.push_back(8'd1);
                3, 4, 5: file_bytes.push_back(8'd3);
                6:       file_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'd0 : 8'hff);
                default: file_bytes.push_back(8'($urandom));
            endcase
        end
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
        // truncated file
        if ($urandom_range(0, 5) == 0) begin
            nlen = $urandom_range(1, file_bytes.size());
            file_bytes = file_bytes[0:nlen-1];
        end
    endfunction

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        tracker = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill bytes, stray data, a one-byte length, header ending on the last byte
        file_bytes = '{8'hff, 8'hd8, 8'h12, 8'hff, 8'hff, 8'hc4, 8'h00, 8'h01,
                       8'hff, 8'hc1, 8'h00, 8'h11, 8'h08, 8'h00, 8'h01, 8'h00,
                       8'h01, 8'h01};
        send_file();
        // one-byte file, nothing found
        file_bytes = '{8'h7f};
        send_file();
        // skipped segment holding marker-like bytes, max size, bad component count,
        // bytes after the report are ignored
        file_bytes = '{8'hff, 8'hd8, 8'hff, 8'he0, 8'h00, 8'h00, 8'hff, 8'hdb,
                       8'h00, 8'h05, 8'hff, 8'hc0, 8'hff, 8'hff, 8'hcf, 8'h00,
                       8'h08, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h02, 8'h55,
                       8'haa};
        send_file();

        while (sent_count < ITEM_TARGET) begin
            quiet = sent_count > ITEM_TARGET * 4 / 5;
            build_random_file();
            send_file();
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.expected_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
